>>> src/bbcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbcd_pkg
// Shared types and constants for the binary to blanked BCD digit converter.
// ----------------------------------------------------------------------------
package bbcd_pkg;

    localparam int BIN_W   = 27;
    localparam int DIGITS  = 8;
    localparam int DIGIT_W = 4;
    localparam int BCD_W   = DIGITS * DIGIT_W;
    localparam int TILE_W  = 5;
    localparam int CNT_W   = $clog2(BIN_W);

    localparam logic [BIN_W-1:0]   MAX_VALUE = BIN_W'(99999999);
    localparam logic [BCD_W-1:0]   BCD_MAX   = 32'h9999_9999;
    localparam logic [DIGIT_W-1:0] DABBLE_TH = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;
    localparam logic [TILE_W-1:0]  TILE_BLANK = 5'd0;

    typedef logic [TILE_W-1:0] tile_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_DONE
    } conv_state_t;

endpackage
`default_nettype wire

>>> src/binary_to_bcd_blanked_digits_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_bcd_blanked_digits_core
// Serial binary to 8-digit BCD converter with leading-zero blanked codes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one 27-bit binary_value per item.
//   Output channel out_valid/out_ready carries bcd_word (eight packed BCD
//   digits), one display code per digit (tile_digit7..0: 0 = blank, else
//   (d+1)*2) and the saturated flag.
//   Values above 99999999 are clamped to 99999999 as the item is taken.
//   The conversion is shift-add-3 (double dabble), one input bit per cycle
//   through a 27-bit binary shifter and a 32-bit BCD shifter. After the
//   last shift, in the done state, the display codes are built and loaded
//   with the BCD word into the output register, which raises out_valid.
//   The number of shifts is set by the bit count of the input.
//   in_ready is high only while the converter is idle; a result waiting in
//   the output register does not block the next item from being taken.
//   If the receiver stalls, the finished conversion holds in the shifter
//   until the output register frees up.
//   Reset clears the controller and the output valid; no item is pending.
// ----------------------------------------------------------------------------
module binary_to_bcd_blanked_digits_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [bbcd_pkg::BIN_W-1:0]  binary_value,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [bbcd_pkg::BCD_W-1:0]       bcd_word,
    output logic [bbcd_pkg::TILE_W-1:0]      tile_digit7,
    output logic [bbcd_pkg::TILE_W-1:0]      tile_digit6,
    output logic [bbcd_pkg::TILE_W-1:0]      tile_digit5,
    output logic [bbcd_pkg::TILE_W-1:0]      tile_digit4,
    output logic [bbcd_pkg::TILE_W-1:0]      tile_digit3,
    output logic [bbcd_pkg::TILE_W-1:0]      tile_digit2,
    output logic [bbcd_pkg::TILE_W-1:0]      tile_digit1,
    output logic [bbcd_pkg::TILE_W-1:0]      tile_digit0,
    output logic                             saturated
);
    import bbcd_pkg::*;

    // Controller
    conv_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // Serial datapath
    logic [BIN_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic               sat_reg, sat_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [BCD_W-1:0]   out_bcd_reg, out_bcd_next;
    tile_t              out_tile_reg [DIGITS], out_tile_next [DIGITS];
    logic               out_sat_reg, out_sat_next;

    logic               in_take;
    logic               out_load;
    logic               last_shift;
    logic [BCD_W-1:0]   bcd_adj;
    tile_t              tile_code [DIGITS];

    assign in_take    = in_valid && in_ready;
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign last_shift = (cnt_reg == CNT_W'(BIN_W - 1));

    // Add 3 to every digit of 5 or more ahead of the shift.
    always_comb
    begin
        for (int k = 0; k < DIGITS; k++)
        begin
            if (bcd_reg[k*DIGIT_W +: DIGIT_W] >= DABBLE_TH)
            begin
                bcd_adj[k*DIGIT_W +: DIGIT_W] = bcd_reg[k*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
            end
            else
            begin
                bcd_adj[k*DIGIT_W +: DIGIT_W] = bcd_reg[k*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // Display codes, most significant digit first; units digit always shown.
    always_comb
    begin
        logic shown;
        logic [DIGIT_W-1:0] d;
        shown = 1'b0;
        for (int i = 0; i < DIGITS; i++)
        begin
            d = bcd_reg[(DIGITS-1-i)*DIGIT_W +: DIGIT_W];
            if (i == DIGITS - 1 || d != '0)
            begin
                shown = 1'b1;
            end
            tile_code[DIGITS-1-i] = shown ? ({1'b0, d} + TILE_W'(1)) << 1 : TILE_BLANK;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (last_shift)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and output register next values
    always_comb
    begin
        cnt_next       = cnt_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_bcd_next   = out_bcd_reg;
        out_sat_next   = out_sat_reg;
        for (int i = 0; i < DIGITS; i++)
        begin
            out_tile_next[i] = out_tile_reg[i];
        end
        in_ready = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_take)
                begin
                    cnt_next = '0;
                    bcd_next = '0;
                    if (binary_value > MAX_VALUE)
                    begin
                        bin_next = MAX_VALUE;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        bin_next = binary_value;
                        sat_next = 1'b0;
                    end
                end
            end
            S_SHIFT:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
                bin_next = {bin_reg[BIN_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_bcd_next   = bcd_reg;
                    out_sat_next   = sat_reg;
                    for (int i = 0; i < DIGITS; i++)
                    begin
                        out_tile_next[i] = tile_code[i];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        sat_reg     <= sat_next;
        out_bcd_reg <= out_bcd_next;
        out_sat_reg <= out_sat_next;
        for (int i = 0; i < DIGITS; i++)
        begin
            out_tile_reg[i] <= out_tile_next[i];
        end
    end

    assign out_valid   = out_valid_reg;
    assign bcd_word    = out_bcd_reg;
    assign saturated   = out_sat_reg;
    assign tile_digit7 = out_tile_reg[7];
    assign tile_digit6 = out_tile_reg[6];
    assign tile_digit5 = out_tile_reg[5];
    assign tile_digit4 = out_tile_reg[4];
    assign tile_digit3 = out_tile_reg[3];
    assign tile_digit2 = out_tile_reg[2];
    assign tile_digit1 = out_tile_reg[1];
    assign tile_digit0 = out_tile_reg[0];

    // Assertions
    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_SHIFT && cnt_reg == '0)
        else $error("accepted item did not start a conversion");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT |-> cnt_reg <= CNT_W'(BIN_W - 1))
        else $error("shift counter out of range");

    a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && (!out_valid || out_ready) |=>
            out_valid && state_reg == S_IDLE)
        else $error("finished conversion not loaded into output register");

    a_units_shown: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tile_digit0 != TILE_BLANK)
        else $error("units digit blanked");

    a_sat_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> bcd_word == BCD_MAX)
        else $error("saturated result is not all nines");

endmodule
`default_nettype wire
